// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks a property on every clock edge outside reset
`define SFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checks that an antecedent implies a consequent on the same edge
`define SFP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/sfp_pkg.sv =====
package sfp_pkg;

  localparam int FRAME_BYTES = 56;
  localparam int ADDR_W      = 6;
  localparam int FILL_W      = 6;
  localparam int FIELD_BYTES = 48;

  localparam logic [7:0]  SYNC_A      = 8'hA5;
  localparam logic [7:0]  SYNC_B      = 8'h5A;
  localparam logic [15:0] PAYLOAD_LEN = 16'd24;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_MSB     = 16'h8000;

  // byte offsets inside a frame
  localparam logic [FILL_W-1:0] OFS_VERSION = 6'd2;
  localparam logic [FILL_W-1:0] OFS_TYPE    = 6'd3;
  localparam logic [FILL_W-1:0] OFS_LEN_LO  = 6'd4;
  localparam logic [FILL_W-1:0] OFS_LEN_HI  = 6'd5;
  localparam logic [FILL_W-1:0] OFS_SEQ     = 6'd6;
  localparam logic [FILL_W-1:0] OFS_CRC_END = 6'd53;
  localparam logic [FILL_W-1:0] OFS_CRC_LO  = 6'd54;
  localparam logic [FILL_W-1:0] OFS_CRC_HI  = 6'd55;

  typedef enum logic [2:0] {
    VERDICT_NEED_MORE = 3'd0,
    VERDICT_ACCEPT    = 3'd1,
    VERDICT_REJECT    = 3'd2,
    VERDICT_NACK_LEN  = 3'd3,
    VERDICT_NACK_VER  = 3'd4,
    VERDICT_NACK_CRC  = 3'd5,
    VERDICT_NACK_SEQ  = 3'd6
  } verdict_t;

  typedef enum logic [1:0] {
    CFG_FRAME_VERSION  = 2'd0,
    CFG_TYPE_COMMAND   = 2'd1,
    CFG_TYPE_EMERGENCY = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_JUDGE = 2'd2
  } state_t;

  typedef struct packed {
    logic take;
    logic scan_start;
    logic scan;
    logic judge;
  } ctrl_cmd_t;

  typedef struct packed {
    logic completes;
    logic scan_done;
    logic out_busy;
  } ctrl_stat_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [63:0] frame_sequence;
    logic [63:0] source_time;
    logic [63:0] trace_tag;
    logic [63:0] joint_zero;
    logic [63:0] joint_one;
    logic [63:0] joint_two;
    logic        emergency;
  } result_t;

  // one byte of crc-16/ccitt-false, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // logical frame offset to physical store address, ring of FRAME_BYTES
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                  input logic [FILL_W-1:0] idx);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (ADDR_W+1)'(FRAME_BYTES)) begin
      sum = sum - (ADDR_W+1)'(FRAME_BYTES);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== src/sfp_in_if.sv =====
interface sfp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [63:0] last_sequence;

  modport source(output valid, output data_byte, output last_sequence, input ready);
  modport sink(input valid, input data_byte, input last_sequence, output ready);
endinterface

// ===== src/sfp_out_if.sv =====
interface sfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [63:0] frame_sequence;
  logic [63:0] source_time;
  logic [63:0] trace_tag;
  logic [63:0] joint_zero;
  logic [63:0] joint_one;
  logic [63:0] joint_two;
  logic        emergency;

  modport source(output valid, output verdict, output frame_sequence, output source_time,
                 output trace_tag, output joint_zero, output joint_one, output joint_two,
                 output emergency, input ready);
  modport sink(input valid, input verdict, input frame_sequence, input source_time,
               input trace_tag, input joint_zero, input joint_one, input joint_two,
               input emergency, output ready);
endinterface

// ===== src/sfp_cfg_if.sv =====
interface sfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== src/sfp_ram.sv =====
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sfp_pkg::FRAME_BYTES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sfp_ctrl.sv =====
`include "assert_macros.svh"

module sfp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sfp_pkg::ctrl_stat_t   stat,
  output sfp_pkg::ctrl_cmd_t    cmd
);

  sfp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state_r)
      sfp_pkg::ST_IDLE: begin
        in_ready       = !stat.out_busy;
        cmd.take       = in_valid && !stat.out_busy;
        cmd.scan_start = cmd.take && stat.completes;
        if (cmd.scan_start) begin
          state_nxt = sfp_pkg::ST_SCAN;
        end
      end
      sfp_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = sfp_pkg::ST_JUDGE;
        end
      end
      sfp_pkg::ST_JUDGE: begin
        cmd.judge = 1'b1;
        state_nxt = sfp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sfp_pkg::ST_IDLE;
      end
    endcase
  end

  `SFP_ASSERT_IMPL(a_judge_after_scan, state_r == sfp_pkg::ST_JUDGE, $past(state_r) == sfp_pkg::ST_SCAN, "judge not preceded by scan")
  `SFP_ASSERT_IMPL(a_scan_from_frame_end, state_r == sfp_pkg::ST_SCAN && $past(state_r) == sfp_pkg::ST_IDLE, $past(cmd.take && stat.completes), "scan entered without a closing byte")

endmodule

// ===== src/sfp_datapath.sv =====
`include "assert_macros.svh"

module sfp_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  sfp_pkg::ctrl_cmd_t  cmd,
  output sfp_pkg::ctrl_stat_t stat,
  input  logic [7:0]          in_data_byte,
  input  logic [63:0]         in_last_sequence,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output sfp_pkg::result_t    out_item
);

  localparam int AW = sfp_pkg::ADDR_W;
  localparam int FW = sfp_pkg::FILL_W;
  localparam int FIELD_W = 8 * sfp_pkg::FIELD_BYTES;
  localparam logic [FW-1:0] LAST_IDX = FW'(sfp_pkg::FRAME_BYTES - 1);

  logic [7:0] cfg_version_r, cfg_type_cmd_r, cfg_type_em_r;

  logic          hunting_r;
  logic [FW-1:0] fill_r;
  logic [AW-1:0] head_r;
  logic [63:0]   seq_floor_r;

  logic             out_valid_r;
  sfp_pkg::result_t out_item_r;

  // scan pass
  logic [FW-1:0]      scan_cnt_r;
  logic               proc_v_r;
  logic [FW-1:0]      proc_idx_r;
  logic               sync0_r, sync1_r;
  logic [7:0]         ver_r, ty_r, prev_r;
  logic [15:0]        len_r, rx_crc_r, crc_r;
  logic [FIELD_W-1:0] fields_r;
  logic               found_r, last_a5_r;
  logic [FW-1:0]      pos_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  sfp_ram #(.WIDTH(8), .DEPTH(sfp_pkg::FRAME_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic completes;
  assign completes = !hunting_r && (fill_r == LAST_IDX);

  assign stat.completes = completes;
  assign stat.scan_done = proc_v_r && (proc_idx_r == LAST_IDX);
  assign stat.out_busy  = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_item       = out_item_r;

  assign ram_raddr = sfp_pkg::phys_addr(head_r, scan_cnt_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sfp_pkg::phys_addr(head_r, fill_r);
    if (cmd.take) begin
      if (hunting_r) begin
        if (fill_r != '0 && in_data_byte == sfp_pkg::SYNC_B) begin
          ram_we    = 1'b1;
          ram_waddr = sfp_pkg::phys_addr(head_r, FW'(1));
        end else if (in_data_byte == sfp_pkg::SYNC_A) begin
          ram_we    = 1'b1;
          ram_waddr = sfp_pkg::phys_addr(head_r, '0);
        end
      end else begin
        ram_we = 1'b1;
      end
    end
  end

  sfp_pkg::verdict_t verdict;
  sfp_pkg::result_t  judge_item;
  logic              type_cmd, type_em;

  always_comb begin
    type_cmd = (ty_r == cfg_type_cmd_r);
    type_em  = (ty_r == cfg_type_em_r);
    if (!(sync0_r && sync1_r)) begin
      verdict = sfp_pkg::VERDICT_REJECT;
    end else if (len_r != sfp_pkg::PAYLOAD_LEN) begin
      verdict = sfp_pkg::VERDICT_NACK_LEN;
    end else if (ver_r != cfg_version_r) begin
      verdict = sfp_pkg::VERDICT_NACK_VER;
    end else if (!type_cmd && !type_em) begin
      verdict = sfp_pkg::VERDICT_REJECT;
    end else if (rx_crc_r != crc_r) begin
      verdict = sfp_pkg::VERDICT_NACK_CRC;
    end else if (fields_r[63:0] <= seq_floor_r) begin
      verdict = sfp_pkg::VERDICT_NACK_SEQ;
    end else begin
      verdict = sfp_pkg::VERDICT_ACCEPT;
    end
    judge_item         = '0;
    judge_item.verdict = verdict;
    if (verdict == sfp_pkg::VERDICT_ACCEPT) begin
      judge_item.frame_sequence = fields_r[63:0];
      judge_item.source_time    = fields_r[127:64];
      judge_item.trace_tag      = fields_r[191:128];
      judge_item.joint_zero     = fields_r[255:192];
      judge_item.joint_one      = fields_r[319:256];
      judge_item.joint_two      = fields_r[383:320];
      judge_item.emergency      = type_em;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_version_r  <= 8'd1;
      cfg_type_cmd_r <= 8'd1;
      cfg_type_em_r  <= 8'd2;
      hunting_r      <= 1'b1;
      fill_r         <= '0;
      head_r         <= '0;
      out_valid_r    <= 1'b0;
      scan_cnt_r     <= FW'(sfp_pkg::FRAME_BYTES);
      proc_v_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (sfp_pkg::cfg_index_t'(cfg_index))
          sfp_pkg::CFG_FRAME_VERSION:  cfg_version_r  <= cfg_data;
          sfp_pkg::CFG_TYPE_COMMAND:   cfg_type_cmd_r <= cfg_data;
          sfp_pkg::CFG_TYPE_EMERGENCY: cfg_type_em_r  <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.take) begin
        seq_floor_r <= in_last_sequence;
        if (hunting_r) begin
          if (fill_r == '0) begin
            fill_r <= (in_data_byte == sfp_pkg::SYNC_A) ? FW'(1) : '0;
          end else if (in_data_byte == sfp_pkg::SYNC_B) begin
            fill_r    <= FW'(2);
            hunting_r <= 1'b0;
          end else begin
            fill_r <= (in_data_byte == sfp_pkg::SYNC_A) ? FW'(1) : '0;
          end
        end else begin
          fill_r <= fill_r + FW'(1);
        end
        if (!completes) begin
          out_valid_r <= 1'b1;
          out_item_r  <= '0;
        end
      end

      if (cmd.scan_start) begin
        scan_cnt_r <= '0;
        proc_v_r   <= 1'b0;
        crc_r      <= sfp_pkg::CRC_INIT;
        found_r    <= 1'b0;
      end else if (cmd.scan) begin
        proc_v_r   <= (scan_cnt_r < FW'(sfp_pkg::FRAME_BYTES));
        proc_idx_r <= scan_cnt_r;
        if (scan_cnt_r < FW'(sfp_pkg::FRAME_BYTES)) begin
          scan_cnt_r <= scan_cnt_r + FW'(1);
        end
      end

      if (proc_v_r) begin
        prev_r <= ram_rdata;
        if (proc_idx_r == '0)                  sync0_r        <= (ram_rdata == sfp_pkg::SYNC_A);
        if (proc_idx_r == FW'(1))              sync1_r        <= (ram_rdata == sfp_pkg::SYNC_B);
        if (proc_idx_r == sfp_pkg::OFS_VERSION) ver_r         <= ram_rdata;
        if (proc_idx_r == sfp_pkg::OFS_TYPE)    ty_r          <= ram_rdata;
        if (proc_idx_r == sfp_pkg::OFS_LEN_LO)  len_r[7:0]    <= ram_rdata;
        if (proc_idx_r == sfp_pkg::OFS_LEN_HI)  len_r[15:8]   <= ram_rdata;
        if (proc_idx_r == sfp_pkg::OFS_CRC_LO)  rx_crc_r[7:0] <= ram_rdata;
        if (proc_idx_r == sfp_pkg::OFS_CRC_HI) begin
          rx_crc_r[15:8] <= ram_rdata;
          last_a5_r      <= (ram_rdata == sfp_pkg::SYNC_A);
        end
        if (proc_idx_r >= sfp_pkg::OFS_VERSION && proc_idx_r <= sfp_pkg::OFS_CRC_END) begin
          crc_r <= sfp_pkg::crc_byte(crc_r, ram_rdata);
        end
        if (proc_idx_r >= sfp_pkg::OFS_SEQ && proc_idx_r <= sfp_pkg::OFS_CRC_END) begin
          fields_r <= {ram_rdata, fields_r[FIELD_W-1:8]};
        end
        // first later sync word, starting at offset one
        if (proc_idx_r >= FW'(2) && !found_r && prev_r == sfp_pkg::SYNC_A &&
            ram_rdata == sfp_pkg::SYNC_B) begin
          found_r <= 1'b1;
          pos_r   <= proc_idx_r - FW'(1);
        end
      end

      if (cmd.judge) begin
        out_valid_r <= 1'b1;
        out_item_r  <= judge_item;
        if (verdict == sfp_pkg::VERDICT_ACCEPT) begin
          hunting_r <= 1'b1;
          fill_r    <= '0;
        end else if (found_r) begin
          head_r    <= sfp_pkg::phys_addr(head_r, pos_r);
          fill_r    <= FW'(sfp_pkg::FRAME_BYTES) - pos_r;
          hunting_r <= 1'b0;
        end else if (last_a5_r) begin
          head_r    <= sfp_pkg::phys_addr(head_r, LAST_IDX);
          fill_r    <= FW'(1);
          hunting_r <= 1'b1;
        end else begin
          hunting_r <= 1'b1;
          fill_r    <= '0;
        end
      end
    end
  end

  `SFP_ASSERT_IMPL(a_hunt_fill, hunting_r, fill_r <= FW'(1), "hunt holds more than one byte")
  `SFP_ASSERT(a_head_range, head_r < AW'(sfp_pkg::FRAME_BYTES), "ring head out of range")

endmodule

// ===== src/synced_crc_frame_parser.sv =====
// channel | dir | handshake    | payload
// in_ch   | in  | valid/ready  | data_byte, last_sequence
// out_ch  | out | valid/ready  | verdict, frame_sequence, source_time, trace_tag,
//         |     |              | joint_zero, joint_one, joint_two, emergency
// cfg_ch  | in  | valid/ready  | index, data (always ready)
//
// a byte that does not close a frame gives its result the cycle after it is taken;
// the next byte is taken only once that result beat has gone
// a closing byte has its result once the 56-byte store has streamed through its registered
// read port and the frame has been judged; the next byte is taken after that result beat
// rst_n is synchronous: parser hunts for sync with an empty store, registers at 1, 1, 2
// in_ch.ready is low while a result beat waits on out_ch or a frame is being checked
`include "assert_macros.svh"

module synced_crc_frame_parser (
  input  logic      clk,
  input  logic      rst_n,
  sfp_in_if.sink    in_ch,
  sfp_out_if.source out_ch,
  sfp_cfg_if.sink   cfg_ch
);

  sfp_pkg::ctrl_cmd_t  cmd;
  sfp_pkg::ctrl_stat_t stat;
  sfp_pkg::result_t    out_item;
  logic                out_valid;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  sfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfp_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_data_byte     (in_ch.data_byte),
    .in_last_sequence (in_ch.last_sequence),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_ready        (out_ch.ready),
    .out_valid        (out_valid),
    .out_item         (out_item)
  );

  // result beat straight from the output register
  assign out_ch.valid          = out_valid;
  assign out_ch.verdict        = out_item.verdict;
  assign out_ch.frame_sequence = out_item.frame_sequence;
  assign out_ch.source_time    = out_item.source_time;
  assign out_ch.trace_tag      = out_item.trace_tag;
  assign out_ch.joint_zero     = out_item.joint_zero;
  assign out_ch.joint_one      = out_item.joint_one;
  assign out_ch.joint_two      = out_item.joint_two;
  assign out_ch.emergency      = out_item.emergency;

  `SFP_ASSERT_IMPL(a_one_in_flight, in_ch.valid && in_ch.ready, !out_ch.valid, "byte taken while a result waits")

endmodule
